// File: hdl/pfs_pkg.sv
package pfs_pkg;

   localparam logic [1:0] REQ_FMT   = 2'd0;
   localparam logic [1:0] REQ_STR   = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_D       = 8'h64;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_S       = 8'h73;

   localparam int          DecDigits  = 10;
   localparam logic [30:0] CountMax   = 31'h7fffffff;
   localparam logic [3:0]  NullLen    = 4'd6;
   localparam logic [4:0]  LastBit    = 5'd31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_CHAR,
      ACT_NULL,
      ACT_DEC,
      ACT_HEX
   } act_type;

   typedef struct packed {
      logic idle;
      logic step;
      logic size;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic    req_fire;
      act_type act;
      logic    step_done;
      logic    emit_ok;
      logic    emit_last;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h57 + {4'h0, nib};
      end
      return c;
   endfunction

   function automatic logic [7:0] null_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h28;
         3'd1:    c = 8'h6e;
         3'd2:    c = 8'h75;
         3'd3:    c = 8'h6c;
         3'd4:    c = 8'h6c;
         3'd5:    c = 8'h29;
         default: c = 8'h29;
      endcase
      return c;
   endfunction

endpackage

// File: hdl/pfs_req_if.sv
interface pfs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  in_byte;
   logic [31:0] arg_value;
   logic        arg_null;

   modport source (output valid, req_type, in_byte, arg_value, arg_null, input ready);
   modport sink   (input valid, req_type, in_byte, arg_value, arg_null, output ready);
endinterface

// File: hdl/pfs_rsp_if.sv
interface pfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_char;
   logic        run_last;
   logic [30:0] chars_written;

   modport source (output valid, out_char, run_last, chars_written, input ready);
   modport sink   (input valid, out_char, run_last, chars_written, output ready);
endinterface

// File: hdl/pfs_ctrl.sv
module pfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  pfs_pkg::status_type st,
   output pfs_pkg::cmd_type    cmd
);

   pfs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         pfs_pkg::ST_IDLE: begin
            cmd.idle = 1'b1;
            if (st.req_fire) begin
               unique case (st.act)
                  pfs_pkg::ACT_CHAR, pfs_pkg::ACT_NULL: state_in = pfs_pkg::ST_EMIT;
                  pfs_pkg::ACT_DEC:                     state_in = pfs_pkg::ST_CONVERT;
                  pfs_pkg::ACT_HEX:                     state_in = pfs_pkg::ST_SIZE;
                  default:                              state_in = pfs_pkg::ST_IDLE;
               endcase
            end
         end
         pfs_pkg::ST_CONVERT: begin
            cmd.step = 1'b1;
            if (st.step_done) begin
               state_in = pfs_pkg::ST_SIZE;
            end
         end
         pfs_pkg::ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = pfs_pkg::ST_EMIT;
         end
         pfs_pkg::ST_EMIT: begin
            cmd.emit = st.emit_ok;
            if (st.emit_ok && st.emit_last) begin
               state_in = pfs_pkg::ST_IDLE;
            end
         end
         default: state_in = pfs_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: hdl/pfs_dpath.sv
module pfs_dpath (
   input  logic                clock,
   input  logic                reset,
   pfs_req_if.sink             req_ch,
   pfs_rsp_if.source           rsp_ch,
   input  pfs_pkg::cmd_type    cmd,
   output pfs_pkg::status_type st
);

   logic                        pending_ff, pending_in;
   logic [30:0]                 total_ff, total_in;
   logic [9:0][3:0]             digits_ff, digits_in;
   logic [31:0]                 bin_ff, bin_in;
   logic [4:0]                  bit_cnt_ff, bit_cnt_in;
   logic                        sign_ff, sign_in;
   logic [3:0]                  rem_ff, rem_in;
   pfs_pkg::act_type            mode_ff, mode_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  out_char_ff, out_char_in;
   logic                        run_last_ff, run_last_in;
   logic [30:0]                 chars_ff, chars_in;

   pfs_pkg::act_type act;
   logic             fire;
   logic [9:0][3:0]  adj;
   logic [3:0]       ndig;
   logic [3:0]       nib_idx;
   logic [7:0]       emit_char;
   logic [30:0]      total_inc;

   assign req_ch.ready     = cmd.idle;
   assign fire             = cmd.idle && req_ch.valid;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_char  = out_char_ff;
   assign rsp_ch.run_last  = run_last_ff;
   assign rsp_ch.chars_written = chars_ff;

   always_comb begin
      act = pfs_pkg::ACT_NONE;
      unique case (req_ch.req_type)
         pfs_pkg::REQ_STR: begin
            if (req_ch.in_byte != pfs_pkg::CHAR_NUL) begin
               act = pfs_pkg::ACT_CHAR;
            end
         end
         pfs_pkg::REQ_FMT: begin
            priority if (req_ch.in_byte == pfs_pkg::CHAR_NUL) begin
               act = pfs_pkg::ACT_NONE;
            end else if (pending_ff) begin
               priority if (req_ch.in_byte == pfs_pkg::CHAR_D) begin
                  act = pfs_pkg::ACT_DEC;
               end else if (req_ch.in_byte == pfs_pkg::CHAR_X) begin
                  act = pfs_pkg::ACT_HEX;
               end else if (req_ch.in_byte == pfs_pkg::CHAR_S && req_ch.arg_null) begin
                  act = pfs_pkg::ACT_NULL;
               end else begin
                  act = pfs_pkg::ACT_NONE;
               end
            end else if (req_ch.in_byte == pfs_pkg::CHAR_PERCENT) begin
               act = pfs_pkg::ACT_NONE;
            end else begin
               act = pfs_pkg::ACT_CHAR;
            end
         end
         default: act = pfs_pkg::ACT_NONE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < pfs_pkg::DecDigits; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
   end

   always_comb begin
      ndig = 4'd1;
      for (int i = 0; i < pfs_pkg::DecDigits; i++) begin
         if (digits_ff[i] != 4'h0) begin
            ndig = 4'(i + 1);
         end
      end
   end

   assign nib_idx   = rem_ff - 4'd1;
   assign total_inc = (total_ff == pfs_pkg::CountMax) ? total_ff : total_ff + 31'd1;

   always_comb begin
      unique case (mode_ff)
         pfs_pkg::ACT_CHAR: emit_char = byte_ff;
         pfs_pkg::ACT_NULL: emit_char = pfs_pkg::null_char(3'(pfs_pkg::NullLen - rem_ff));
         pfs_pkg::ACT_DEC, pfs_pkg::ACT_HEX: begin
            emit_char = sign_ff ? pfs_pkg::CHAR_MINUS : pfs_pkg::hex_char(digits_ff[nib_idx]);
         end
         default: emit_char = byte_ff;
      endcase
   end

   always_comb begin
      st.req_fire  = fire;
      st.act       = act;
      st.step_done = (bit_cnt_ff == pfs_pkg::LastBit);
      st.emit_ok   = !rsp_valid_ff || rsp_ch.ready;
      st.emit_last = !sign_ff && (rem_ff == 4'd1);
   end

   always_comb begin
      pending_in   = pending_ff;
      total_in     = total_ff;
      digits_in    = digits_ff;
      bin_in       = bin_ff;
      bit_cnt_in   = bit_cnt_ff;
      sign_in      = sign_ff;
      rem_in       = rem_ff;
      mode_in      = mode_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_char_in  = out_char_ff;
      run_last_in  = run_last_ff;
      chars_in     = chars_ff;

      if (fire) begin
         mode_in = act;
         byte_in = req_ch.in_byte;
         sign_in = 1'b0;
         unique case (req_ch.req_type)
            pfs_pkg::REQ_START: begin
               total_in   = '0;
               pending_in = 1'b0;
            end
            pfs_pkg::REQ_FMT: begin
               pending_in = !pending_ff && (req_ch.in_byte == pfs_pkg::CHAR_PERCENT);
            end
            default: pending_in = pending_ff;
         endcase
         unique case (act)
            pfs_pkg::ACT_CHAR: rem_in = 4'd1;
            pfs_pkg::ACT_NULL: rem_in = pfs_pkg::NullLen;
            pfs_pkg::ACT_DEC: begin
               sign_in    = req_ch.arg_value[31];
               bin_in     = req_ch.arg_value[31] ? (32'd0 - req_ch.arg_value)
                                                 : req_ch.arg_value;
               digits_in  = '0;
               bit_cnt_in = '0;
            end
            pfs_pkg::ACT_HEX: digits_in = {8'h00, req_ch.arg_value};
            default: rem_in = rem_ff;
         endcase
      end

      if (cmd.step) begin
         digits_in  = {adj[9][2:0], adj[8:0], bin_ff[31]};
         bin_in     = {bin_ff[30:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 5'd1;
      end

      if (cmd.size) begin
         rem_in = ndig;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         out_char_in  = emit_char;
         run_last_in  = st.emit_last;
         chars_in     = total_inc;
         total_in     = total_inc;
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            rem_in = rem_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         rem_ff       <= '0;
         bit_cnt_ff   <= '0;
         mode_ff      <= pfs_pkg::ACT_NONE;
      end else begin
         pending_ff   <= pending_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         rem_ff       <= rem_in;
         bit_cnt_ff   <= bit_cnt_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      bin_ff      <= bin_in;
      byte_ff     <= byte_in;
      out_char_ff <= out_char_in;
      run_last_ff <= run_last_in;
      chars_ff    <= chars_in;
   end

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.emit_ok)
      else $error("emit into occupied output register");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && st.emit_last |=> cmd.idle)
      else $error("controller not idle after last character");

   a_rem_live: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !sign_ff |-> rem_ff != 4'd0)
      else $error("emit with no characters remaining");

endmodule

// File: hdl/printf_subset_formatter.sv
// Channel | Dir | Handshake         | Payload
// req_ch  | in  | valid/ready       | req_type[1:0] in_byte[7:0] arg_value[31:0] arg_null
// rsp_ch  | out | valid/ready       | out_char[7:0] run_last chars_written[30:0]
//
// Literal or string byte: accept, then emit; (null): accept, then emit its six characters. Hex:
// accept, digit count, then the digits, most significant first. Decimal: accept,
// the 32-step binary-to-BCD shift loop, digit count, then a '-' if negative and the digits.
// reset is synchronous; it clears the pending '%', the count and the output.
// A stalled rsp_ch holds the emitter; req_ch is taken only while idle.
module printf_subset_formatter (
   input  logic      clock,
   input  logic      reset,
   pfs_req_if.sink   req_ch,
   pfs_rsp_if.source rsp_ch
);

   pfs_pkg::cmd_type    cmd;
   pfs_pkg::status_type st;

   pfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   pfs_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .st     (st)
   );

endmodule
